>>> sv/tlnvf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlnvf_pkg;

  // character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [6:0] CH_DEL    = 7'h7F;
  localparam logic [6:0] CTRL_LIMIT  = 7'd32;
  localparam logic [7:0] CTRL_OFFSET = 8'd64;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_LINE_ENDS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_TAB_MARKS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd4;

  // numbering modes
  localparam logic [1:0] NM_NONE = 2'd0;
  localparam logic [1:0] NM_ALL  = 2'd1;

  // status of the selected counter digit
  typedef struct packed {
    logic [3:0] digit;
    logic       is_zero;
    logic       is_nine;
  } digit_status_t;

endpackage

`default_nettype wire

>>> sv/tlnvf_counter.sv
`timescale 1ns / 1ps
`default_nettype none

module tlnvf_counter
  import tlnvf_pkg::*;
#(
  parameter int NUM_DIGITS = 10,
  localparam int IW = $clog2(NUM_DIGITS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [IW-1:0] idx_i,
  input  logic          inc_i,
  output digit_status_t status_o
);

  logic [3:0] digits_q [NUM_DIGITS];
  logic [3:0] digit;

  assign digit = digits_q[idx_i];

  always_comb begin
    status_o.digit   = digit;
    status_o.is_zero = (digit == 4'd0);
    status_o.is_nine = (digit >= 4'd9);
  end

  // one decimal digit per step; carry is is_nine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digits_q[i] <= (i == 0) ? 4'd1 : 4'd0;
      end
    end else if (inc_i) begin
      digits_q[idx_i] <= status_o.is_nine ? 4'd0 : digit + 4'd1;
    end
  end

endmodule

`default_nettype wire

>>> sv/text_line_number_visible_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                  Payload
// in        in_valid_i / in_ready_o    data_byte_i
// out       out_valid_o / out_ready_i  out_byte_o, last_of_run_o
// cfg       cfg_we_i                   cfg_idx_i, cfg_data_i
//
// Plain byte: accept, then one cycle per output byte, up to 4.
// Numbered line start adds a digit scan down to the top nonzero digit,
// one cycle per pad, digit and tab byte, and a ripple increment over the
// carrying digits, all through the single digit unit of the counter.
// A stalled output holds the sequencer; one output register decouples it.
// Reset: counter 1, at line start, no empty run, all options off.

module text_line_number_visible_filter
  import tlnvf_pkg::*;
#(
  parameter int NUM_DIGITS = 10,
  parameter int PAD_WIDTH  = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  last_of_run_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IW = $clog2(NUM_DIGITS);
  localparam int PW = $clog2(PAD_WIDTH + 1);
  localparam int CW = (IW + 1 > PW) ? IW + 1 : PW;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_DIGITS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_PAD   = 3'd2;
  localparam logic [2:0] S_DIGIT = 3'd3;
  localparam logic [2:0] S_TAB   = 3'd4;
  localparam logic [2:0] S_BODY  = 3'd5;
  localparam logic [2:0] S_INC   = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [PW-1:0] pad_q, pad_d;
  logic          nine_q, nine_d;
  logic          num_q, num_d;
  logic [7:0]    body_q [4];
  logic [2:0]    blen_q;
  logic [1:0]    bpos_q, bpos_d;
  logic          at_ls_q, at_ls_d;
  logic [1:0]    empty_run_q, empty_run_d;

  logic [1:0] number_mode_q;
  logic       show_line_ends_q, show_tab_marks_q, show_nonprinting_q, squeeze_blank_q;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  logic       slot_free, emit_en, emit_last;
  logic [7:0] emit_byte;
  logic       accept, load_body, inc_en;

  digit_status_t st;

  tlnvf_counter #(.NUM_DIGITS(NUM_DIGITS)) u_counter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .idx_i    (idx_q),
    .inc_i    (inc_en),
    .status_o (st)
  );

  // expansion of the current byte
  logic [7:0] bb [4];
  logic [2:0] blen_c;
  logic [7:0] tail0, tail1;
  logic [1:0] tlen;
  logic [6:0] c7;

  always_comb begin
    c7    = data_byte_i[6:0];
    tail0 = {1'b0, c7};
    tail1 = CH_QMARK;
    tlen  = 2'd1;
    if (c7 < CTRL_LIMIT) begin
      tail0 = CH_CARET;
      tail1 = {1'b0, c7} + CTRL_OFFSET;
      tlen  = 2'd2;
    end else if (c7 == CH_DEL) begin
      tail0 = CH_CARET;
      tail1 = CH_QMARK;
      tlen  = 2'd2;
    end
    bb[0]  = data_byte_i;
    bb[1]  = CH_NL;
    bb[2]  = tail0;
    bb[3]  = tail1;
    blen_c = 3'd1;
    if (data_byte_i == CH_NL) begin
      if (show_line_ends_q) begin
        bb[0]  = CH_DOLLAR;
        blen_c = 3'd2;
      end
    end else if (data_byte_i == CH_TAB) begin
      if (show_tab_marks_q) begin
        bb[0]  = CH_CARET;
        bb[1]  = CH_I;
        blen_c = 3'd2;
      end
    end else if (show_nonprinting_q) begin
      if (data_byte_i[7]) begin
        bb[0]  = CH_M;
        bb[1]  = CH_DASH;
        blen_c = 3'd2 + {1'b0, tlen};
      end else begin
        bb[0]  = tail0;
        bb[1]  = tail1;
        blen_c = {1'b0, tlen};
      end
    end
  end

  logic          is_nl, blank, squeezed, num_c;
  logic [1:0]    er_inc;
  logic [CW-1:0] top_plus, pad_calc;
  logic          need_pad;

  always_comb begin
    is_nl    = (data_byte_i == CH_NL);
    blank    = at_ls_q && is_nl;
    er_inc   = (empty_run_q == 2'd3) ? 2'd3 : empty_run_q + 2'd1;
    squeezed = blank && squeeze_blank_q && (er_inc > 2'd1);
    num_c    = blank ? (number_mode_q == NM_ALL)
                     : (at_ls_q && (number_mode_q != NM_NONE));
    top_plus = CW'(idx_q) + CW'(1);
    need_pad = top_plus < CW'(PAD_WIDTH);
    pad_calc = CW'(PAD_WIDTH) - top_plus;
  end

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pad_d       = pad_q;
    nine_d      = nine_q;
    num_d       = num_q;
    bpos_d      = bpos_q;
    at_ls_d     = at_ls_q;
    empty_run_d = empty_run_q;
    load_body   = 1'b0;
    inc_en      = 1'b0;
    emit_en     = 1'b0;
    emit_byte   = CH_SPACE;
    emit_last   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          load_body = 1'b1;
          num_d     = num_c;
          at_ls_d   = is_nl;
          bpos_d    = 2'd0;
          if (blank) begin
            if (squeeze_blank_q) empty_run_d = er_inc;
          end else if (at_ls_q) begin
            empty_run_d = 2'd0;
          end
          if (squeezed) begin
            state_d = S_IDLE;
          end else if (num_c) begin
            idx_d   = LAST_IDX;
            state_d = S_SCAN;
          end else begin
            state_d = S_BODY;
          end
        end
      end
      S_SCAN: begin
        if (!st.is_zero || idx_q == '0) begin
          nine_d  = (idx_q == LAST_IDX);
          pad_d   = PW'(pad_calc);
          state_d = need_pad ? S_PAD : S_DIGIT;
        end else begin
          idx_d = idx_q - IW'(1);
        end
      end
      S_PAD: begin
        if (slot_free) begin
          emit_en = 1'b1;
          pad_d   = pad_q - PW'(1);
          if (pad_q == PW'(1)) state_d = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (slot_free) begin
          emit_en   = 1'b1;
          emit_byte = CH_ZERO | {4'd0, st.digit};
          nine_d    = nine_q && st.is_nine;
          if (idx_q == '0) state_d = S_TAB;
          else idx_d = idx_q - IW'(1);
        end
      end
      S_TAB: begin
        if (slot_free) begin
          emit_en   = 1'b1;
          emit_byte = CH_TAB;
          state_d   = S_BODY;
        end
      end
      S_BODY: begin
        if (slot_free) begin
          emit_en   = 1'b1;
          emit_byte = body_q[bpos_q];
          emit_last = ({1'b0, bpos_q} == blen_q - 3'd1);
          if (emit_last) begin
            if (num_q && !nine_q) begin
              idx_d   = '0;
              state_d = S_INC;
            end else begin
              state_d = S_IDLE;
            end
          end else begin
            bpos_d = bpos_q + 2'd1;
          end
        end
      end
      S_INC: begin
        inc_en = 1'b1;
        if (st.is_nine && idx_q != LAST_IDX) idx_d = idx_q + IW'(1);
        else state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= S_IDLE;
      idx_q              <= '0;
      pad_q              <= '0;
      nine_q             <= 1'b0;
      num_q              <= 1'b0;
      bpos_q             <= 2'd0;
      at_ls_q            <= 1'b1;
      empty_run_q        <= 2'd0;
      out_valid_q        <= 1'b0;
      number_mode_q      <= NM_NONE;
      show_line_ends_q   <= 1'b0;
      show_tab_marks_q   <= 1'b0;
      show_nonprinting_q <= 1'b0;
      squeeze_blank_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pad_q       <= pad_d;
      nine_q      <= nine_d;
      num_q       <= num_d;
      bpos_q      <= bpos_d;
      at_ls_q     <= at_ls_d;
      empty_run_q <= empty_run_d;
      if (emit_en) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_NUMBER_MODE:      number_mode_q      <= cfg_data_i;
          REG_SHOW_LINE_ENDS:   show_line_ends_q   <= cfg_data_i[0];
          REG_SHOW_TAB_MARKS:   show_tab_marks_q   <= cfg_data_i[0];
          REG_SHOW_NONPRINTING: show_nonprinting_q <= cfg_data_i[0];
          REG_SQUEEZE_BLANK:    squeeze_blank_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_en) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
    if (load_body) begin
      for (int i = 0; i < 4; i++) body_q[i] <= bb[i];
      blen_q <= blen_c;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

  // the line counter never reads as zero, so the scan stops on a real digit
  a_scan_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && idx_q == '0) |-> !st.is_zero)
    else $error("line counter scanned as zero");

  a_pad_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PAD) |-> (pad_q != '0))
    else $error("pad state with no pad left");

  a_number_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && at_ls_q && data_byte_i != CH_NL && number_mode_q != NM_NONE)
      |=> (state_q == S_SCAN))
    else $error("numbered line start did not begin a digit scan");

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_en && emit_last) |=> (state_q == S_IDLE || state_q == S_INC))
    else $error("sequencer kept emitting after the last byte");

endmodule

`default_nettype wire

>>> tb/tb_text_line_number_visible_filter.sv
`timescale 1ns / 1ps

module tb_text_line_number_visible_filter;
  import tlnvf_pkg::*;

  localparam int NUM_DIGITS    = 10;
  localparam int PAD_WIDTH     = 6;
  localparam int SETTLE_CYCLES = 4 * NUM_DIGITS + 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LINE_MAX      = 8;
  localparam int PHASE_ITEMS   = 35;
  localparam int GAP_MAX       = 40;

  localparam logic [1:0] NM_NONEMPTY = 2'd2;
  localparam logic [1:0] NM_UNDEF    = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       last_flag;
  } out_beat_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [7:0]            data_byte_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [7:0]            out_byte_o;
  logic                  last_of_run_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // formatter state as the block should hold it
  logic [1:0]              num_mode;
  logic                    mark_ends;
  logic                    mark_tabs;
  logic                    mark_nonprint;
  logic                    squeeze_en;
  logic [4*NUM_DIGITS-1:0] line_num;
  logic                    line_start;
  logic [1:0]              empty_lines;

  logic [7:0]  step_bytes[$];
  out_beat_t   formatted_q[$];

  int unsigned src_idle_pct   = 0;
  int unsigned sink_idle_pct  = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  text_line_number_visible_filter #(
    .NUM_DIGITS(NUM_DIGITS),
    .PAD_WIDTH (PAD_WIDTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .last_of_run_o(last_of_run_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------- predictor

  task automatic put_line_number();
    int top;
    bit all_nine;
    bit carry;
    top = 0;
    for (int i = 0; i < NUM_DIGITS; i++)
      if (line_num[4*i +: 4] != 4'd0) top = i;
    for (int i = PAD_WIDTH - (top + 1); i > 0; i--) step_bytes.push_back(CH_SPACE);
    for (int i = top; i >= 0; i--) step_bytes.push_back(CH_ZERO + line_num[4*i +: 4]);
    step_bytes.push_back(CH_TAB);
    all_nine = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++)
      if (line_num[4*i +: 4] != 4'd9) all_nine = 1'b0;
    if (!all_nine) begin
      carry = 1'b1;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        if (carry) begin
          if (line_num[4*i +: 4] >= 4'd9) begin
            line_num[4*i +: 4] = 4'd0;
          end else begin
            line_num[4*i +: 4] = line_num[4*i +: 4] + 4'd1;
            carry = 1'b0;
          end
        end
      end
    end
  endtask

  task automatic put_newline();
    if (mark_ends) step_bytes.push_back(CH_DOLLAR);
    step_bytes.push_back(CH_NL);
  endtask

  task automatic format_byte(input logic [7:0] c);
    logic [7:0] v;
    out_beat_t  beat;
    step_bytes.delete();
    if (line_start && c == CH_NL) begin
      if (squeeze_en && empty_lines < 2'd3) empty_lines = empty_lines + 2'd1;
      if (!(squeeze_en && empty_lines > 2'd1)) begin
        if (num_mode == NM_ALL) put_line_number();
        put_newline();
      end
    end else begin
      if (line_start) begin
        empty_lines = 2'd0;
        if (num_mode != NM_NONE) put_line_number();
        line_start = 1'b0;
      end
      if (c == CH_NL) begin
        put_newline();
        line_start = 1'b1;
      end else if (c == CH_TAB) begin
        if (mark_tabs) begin
          step_bytes.push_back(CH_CARET);
          step_bytes.push_back(CH_I);
        end else begin
          step_bytes.push_back(CH_TAB);
        end
      end else if (mark_nonprint) begin
        v = c;
        if (v[7]) begin
          step_bytes.push_back(CH_M);
          step_bytes.push_back(CH_DASH);
          v[7] = 1'b0;
        end
        if (v < {1'b0, CTRL_LIMIT}) begin
          step_bytes.push_back(CH_CARET);
          step_bytes.push_back(v + CTRL_OFFSET);
        end else if (v[6:0] == CH_DEL) begin
          step_bytes.push_back(CH_CARET);
          step_bytes.push_back(CH_QMARK);
        end else begin
          step_bytes.push_back(v);
        end
      end else begin
        step_bytes.push_back(c);
      end
    end
    for (int k = 0; k < step_bytes.size(); k++) begin
      beat.ch        = step_bytes[k];
      beat.last_flag = (k == step_bytes.size() - 1);
      formatted_q.push_back(beat);
    end
  endtask

  // ----------------------------------------------------------------- drivers

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_NUMBER_MODE:      num_mode      = val;
      REG_SHOW_LINE_ENDS:   mark_ends     = val[0];
      REG_SHOW_TAB_MARKS:   mark_tabs     = val[0];
      REG_SHOW_NONPRINTING: mark_nonprint = val[0];
      REG_SQUEEZE_BLANK:    squeeze_en    = val[0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [CFG_DATA_W-1:0] mode,
                             input logic [CFG_DATA_W-1:0] ends,
                             input logic [CFG_DATA_W-1:0] tabs,
                             input logic [CFG_DATA_W-1:0] nonprint,
                             input logic [CFG_DATA_W-1:0] squeeze);
    write_reg(REG_NUMBER_MODE, mode);
    write_reg(REG_SHOW_LINE_ENDS, ends);
    write_reg(REG_SHOW_TAB_MARKS, tabs);
    write_reg(REG_SHOW_NONPRINTING, nonprint);
    write_reg(REG_SQUEEZE_BLANK, squeeze);
    // unused index, must be ignored
    write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, REG_SQUEEZE_BLANK + 1)),
              CFG_DATA_W'($urandom_range(3)));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    while (gap < GAP_MAX && $urandom_range(99) < src_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    format_byte(b);
  endtask

  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    while (formatted_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] random_text_byte();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 12) return CH_TAB;
    else if (pick < 24) return 8'($urandom_range(31, 0));
    else if (pick < 38) return 8'($urandom_range(255, 127));
    else return 8'($urandom_range(126, 32));
  endfunction

  task automatic send_text(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(3) == 0) ? 0 : $urandom_range(LINE_MAX, 1);
      for (int i = 0; i < len && sent < n_items; i++) begin
        send_byte(random_text_byte());
        sent++;
      end
      if (sent < n_items) begin
        send_byte(CH_NL);
        sent++;
      end
    end
  endtask

  // ------------------------------------------------------------------ checker

  always @(posedge clk_i) begin : out_check
    out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (formatted_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction byte %h last %b",
                                  out_byte_o, last_of_run_o));
      end else begin
        want = formatted_q.pop_front();
        if (out_byte_o !== want.ch)
          report_mismatch($sformatf("out_byte %h, expected %h", out_byte_o, want.ch));
        if (last_of_run_o !== want.last_flag)
          report_mismatch($sformatf("last_of_run %b, expected %b on byte %h",
                                    last_of_run_o, want.last_flag, want.ch));
      end
    end
    out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
  end

  // -------------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    send_byte(8'h41);
    send_byte(CH_TAB);
    send_byte(CH_NL);
    send_byte(8'h00);
    send_byte(8'hFF);
    drain_outputs();
  endtask

  task automatic test_visible_marks();
    // 2-bit data on 1-bit registers: only bit 0 counts
    load_config(NM_NONE, 2'd3, 2'd1, 2'd1, 2'd2);
    send_byte(8'h00);
    send_byte(8'h1F);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h9F);
    send_byte(8'hA0);
    send_byte(CH_TAB);
    send_byte(8'h89);
    send_byte(CH_NL);
    drain_outputs();
  endtask

  task automatic test_blank_squeeze();
    load_config(NM_ALL, 2'd0, 2'd0, 2'd0, 2'd1);
    repeat (5) send_byte(CH_NL);
    send_byte(8'h78);
    send_byte(CH_NL);
    drain_outputs();
  endtask

  task automatic test_undefined_mode();
    load_config(NM_UNDEF, 2'd1, 2'd0, 2'd0, 2'd0);
    send_byte(CH_NL);
    send_byte(8'h79);
    send_byte(CH_NL);
    drain_outputs();
  endtask

  task automatic test_random_text(input int unsigned src_pct, input int unsigned sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: load_config(NM_NONE, 2'd0, 2'd0, 2'd0, 2'd0);
        1: load_config(NM_NONEMPTY, 2'd1, 2'd1, 2'd1, 2'd1);
        default: load_config(CFG_DATA_W'($urandom_range(3)), CFG_DATA_W'($urandom_range(3)),
                             CFG_DATA_W'($urandom_range(3)), CFG_DATA_W'($urandom_range(3)),
                             CFG_DATA_W'($urandom_range(3)));
      endcase
      send_text(PHASE_ITEMS);
      drain_outputs();
    end
  endtask

  initial begin
    num_mode      = NM_NONE;
    mark_ends     = 1'b0;
    mark_tabs     = 1'b0;
    mark_nonprint = 1'b0;
    squeeze_en    = 1'b0;
    line_num      = '0;
    line_num[3:0] = 4'd1;
    line_start    = 1'b1;
    empty_lines   = 2'd0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_idle_pct  = 19;
    sink_idle_pct = 77;
    test_reset_defaults();
    test_visible_marks();
    test_blank_squeeze();
    test_undefined_mode();
    test_random_text(19, 77);
    test_random_text(77, 19);
    test_random_text(0, 0);
    if (mismatch_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

endmodule
